[hw/rtl/puso_pkg.sv]
// Shared constants for the permutation unrank block: field widths, reset value of
// the column count and the reciprocal table used by the divide step of each cell.
// No dependencies.
package puso_pkg;

	localparam int DEF_MAX_COLUMNS = 8;

	localparam int INDEX_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int ORDER_W    = 32;
	localparam int FIELD_W    = 4;
	localparam int PACK_SLOTS = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd6;

	// ceil(2^RECIP_SHIFT / r); exact quotient for 16-bit dividends and r up to 16
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 21;
	localparam int RADIX_TBL_W = 5;
	localparam int RADIX_TBL_N = 17;
	localparam int PROD_W      = INDEX_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP_TBL [RADIX_TBL_N] = '{
		21'd0,      21'd1048576, 21'd524288, 21'd349526,
		21'd262144, 21'd209716,  21'd174763, 21'd149797,
		21'd131072, 21'd116509,  21'd104858, 21'd95326,
		21'd87382,  21'd80660,   21'd74899,  21'd69906,
		21'd65536
	};

endpackage

[hw/rtl/puso_ifs.sv]
// Valid/ready channel interfaces: rank input, order output and configuration write.
// Depends on puso_pkg.
interface puso_index_if import puso_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] perm_index;

	modport source (output valid, output perm_index, input ready);
	modport sink   (input valid, input perm_index, output ready);
endinterface

interface puso_order_if import puso_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ORDER_W-1:0] packed_order;
	logic               index_overflow;

	modport source (output valid, output packed_order, output index_overflow, input ready);
	modport sink   (input valid, input packed_order, input index_overflow, output ready);
endinterface

interface puso_cfg_if import puso_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/puso_cell.sv]
// One position of the unranking chain: divides the remaining rank by its radix
// (reciprocal multiply, registered) and then swaps the picked entry into place.
// Depends on puso_pkg.
module puso_cell import puso_pkg::*; #(
	parameter  int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter  int CELL_IDX    = 0,
	localparam int IW          = $clog2(MAX_COLUMNS),
	localparam int NW          = $clog2(MAX_COLUMNS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [NW-1:0]                    n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [INDEX_W-1:0]               in_rem,
	input  logic [MAX_COLUMNS-1:0][IW-1:0]   in_order,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [INDEX_W-1:0]               out_rem,
	output logic [MAX_COLUMNS-1:0][IW-1:0]   out_order
);

	logic [NW-1:0]                  radix;
	logic                           active;
	logic                           ready_s1, ready_s2;
	logic                           valid_s1, valid_s2;
	logic [INDEX_W-1:0]             rem_s1, rem_s2;
	logic [MAX_COLUMNS-1:0][IW-1:0] order_s1, order_s2;
	logic [PROD_W-1:0]              prod_s1;
	logic [INDEX_W-1:0]             quo, rem_raw, rem_fix, quo_fix;
	logic [IW-1:0]                  digit, pick;
	logic [MAX_COLUMNS-1:0][IW-1:0] order_nxt;
	logic [INDEX_W-1:0]             rem_nxt;

	assign radix  = (n > NW'(CELL_IDX)) ? NW'(n - NW'(CELL_IDX)) : '0;
	assign active = (radix != '0);

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			rem_s1   <= in_rem;
			order_s1 <= in_order;
			prod_s1  <= PROD_W'(in_rem) * PROD_W'(RECIP_TBL[RADIX_TBL_W'(radix)]);
		end
	end

	always_comb begin
		quo     = INDEX_W'(prod_s1[PROD_W-1:RECIP_SHIFT]);
		rem_raw = INDEX_W'(rem_s1 - INDEX_W'(quo * INDEX_W'(radix)));
		quo_fix = quo;
		rem_fix = rem_raw;
		if (rem_raw >= INDEX_W'(radix)) begin
			quo_fix = INDEX_W'(quo + INDEX_W'(1));
			rem_fix = INDEX_W'(rem_raw - INDEX_W'(radix));
		end
		digit     = rem_fix[IW-1:0];
		pick      = IW'(IW'(CELL_IDX) + digit);
		order_nxt = order_s1;
		rem_nxt   = rem_s1;
		if (active) begin
			rem_nxt             = quo_fix;
			order_nxt[CELL_IDX] = order_s1[pick];
			order_nxt[pick]     = order_s1[CELL_IDX];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			rem_s2   <= rem_nxt;
			order_s2 <= order_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_rem   = rem_s2;
	assign out_order = order_s2;

endmodule

[hw/rtl/permutation_unrank_swap_order.sv]
// The rank passes two registers per cell and one output register before the
// result is valid. Throughput: one transaction per cycle unless the output
// stalls; each cell stage stalls on its own.
// Reset: all valid bits cleared, column_count set to 6.
// Depends on puso_pkg, puso_ifs, puso_cell.
module permutation_unrank_swap_order import puso_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  logic          clk,
	input  logic          arst_n,
	puso_cfg_if.sink      cfg,
	puso_index_if.sink    rank,
	puso_order_if.source  order
);

	localparam int IW    = $clog2(MAX_COLUMNS);
	localparam int NW    = $clog2(MAX_COLUMNS + 1);
	localparam int SLOTS = (MAX_COLUMNS < PACK_SLOTS) ? MAX_COLUMNS : PACK_SLOTS;

	logic [COUNT_W-1:0]             count_q;
	logic [NW-1:0]                  n_eff;
	logic                           chain_valid [MAX_COLUMNS+1];
	logic                           chain_ready [MAX_COLUMNS+1];
	logic [INDEX_W-1:0]             chain_rem   [MAX_COLUMNS+1];
	logic [MAX_COLUMNS-1:0][IW-1:0] chain_order [MAX_COLUMNS+1];
	logic                           out_valid_q;
	logic [ORDER_W-1:0]             packed_q;
	logic                           ovf_q;
	logic [ORDER_W-1:0]             packed_nxt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	always_comb begin
		if (32'(count_q) > MAX_COLUMNS) n_eff = NW'(MAX_COLUMNS);
		else n_eff = NW'(count_q);
	end

	assign chain_valid[0] = rank.valid;
	assign rank.ready     = chain_ready[0];
	assign chain_rem[0]   = rank.perm_index;

	always_comb begin
		for (int k = 0; k < MAX_COLUMNS; k++) chain_order[0][k] = IW'(k);
	end

	for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
		puso_cell #(
			.MAX_COLUMNS (MAX_COLUMNS),
			.CELL_IDX    (c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.n         (n_eff),
			.in_valid  (chain_valid[c]),
			.in_ready  (chain_ready[c]),
			.in_rem    (chain_rem[c]),
			.in_order  (chain_order[c]),
			.out_valid (chain_valid[c+1]),
			.out_ready (chain_ready[c+1]),
			.out_rem   (chain_rem[c+1]),
			.out_order (chain_order[c+1])
		);
	end

	assign chain_ready[MAX_COLUMNS] = !out_valid_q || order.ready;

	always_comb begin
		packed_nxt = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (k < n_eff) packed_nxt[FIELD_W*k +: FIELD_W] = FIELD_W'(chain_order[MAX_COLUMNS][k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chain_ready[MAX_COLUMNS]) begin
			out_valid_q <= chain_valid[MAX_COLUMNS];
		end
	end

	// leftover rank after the last division is rank / n!
	always_ff @(posedge clk) begin
		if (chain_ready[MAX_COLUMNS] && chain_valid[MAX_COLUMNS]) begin
			packed_q <= packed_nxt;
			ovf_q    <= (chain_rem[MAX_COLUMNS] != '0);
		end
	end

	assign order.valid          = out_valid_q;
	assign order.packed_order   = packed_q;
	assign order.index_overflow = ovf_q;

endmodule

[hw/rtl/puso_checker.sv]
// Port-level checks for permutation_unrank_swap_order, attached by bind.
// Depends on puso_pkg; shadows the column count from configuration transactions.
module puso_checker import puso_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [COUNT_W-1:0] cfg_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ORDER_W-1:0] packed_order,
	input logic               index_overflow
);

	localparam int CAP = 2 * MAX_COLUMNS + 1;
	localparam int CW  = $clog2(CAP + 1);

	logic [COUNT_W-1:0] shadow_q;
	logic [CW-1:0]      inflight_q;
	logic [COUNT_W:0]   shadow_eff;
	logic               in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign shadow_eff = (32'(shadow_q) > MAX_COLUMNS) ? (COUNT_W+1)'(MAX_COLUMNS)
	                                                  : (COUNT_W+1)'(shadow_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q   <= COUNT_RESET;
			inflight_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) shadow_q <= cfg_data;
			if (in_acc && !out_acc) inflight_q <= CW'(inflight_q + CW'(1));
			else if (!in_acc && out_acc) inflight_q <= CW'(inflight_q - CW'(1));
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_order)
			&& $stable(index_overflow))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without a pending input transaction");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_acc |-> inflight_q < CW'(CAP))
		else $error("more transactions in flight than pipeline stages");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shadow_eff >= (COUNT_W+1)'(PACK_SLOTS))
			|| ((packed_order >> (FIELD_W * shadow_eff)) == '0))
		else $error("unused positions not zero");

	a_trivial_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (shadow_eff <= (COUNT_W+1)'(1)) |-> packed_order == '0)
		else $error("order of one or no columns not zero");

endmodule

bind permutation_unrank_swap_order puso_checker #(
	.MAX_COLUMNS (MAX_COLUMNS)
) u_puso_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_data       (cfg.data),
	.in_valid       (rank.valid),
	.in_ready       (rank.ready),
	.out_valid      (order.valid),
	.out_ready      (order.ready),
	.packed_order   (order.packed_order),
	.index_overflow (order.index_overflow)
);
